### rtl/rfr_pkg.sv
`timescale 1ns / 1ps

package rfr_pkg;

  localparam int MAX_TAG_BYTES = 16;
  localparam int IDX_W = (MAX_TAG_BYTES > 1) ? $clog2(MAX_TAG_BYTES) : 1;
  localparam int LEN_W = $clog2(MAX_TAG_BYTES + 1);

  localparam logic [7:0] START_BYTE = 8'h0A;
  localparam logic [7:0] STOP_BYTE = 8'h0D;
  localparam logic [4:0] DEFAULT_TAG_LENGTH = 5'd10;

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FRAME = 2'd1;
  localparam logic [1:0] ST_BADSTART = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  // register indexes (paddr[2])
  localparam logic REG_TAG_LENGTH = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] tag_byte;
    logic       last;
  } out_item_t;

  // control broadcast to every cell of the ring
  typedef struct packed {
    logic       restart;  // pointer back to cell 0
    logic       advance;  // pointer moves one cell on
    logic       write;    // first copy: pointed cell stores the byte
    logic       compare;  // second copy: pointed cell checks the byte
    logic       rotate;   // every cell takes its right neighbor's byte
    logic [7:0] rx_byte;
  } cell_ctl_t;

  // tag_length clamped to 1..MAX_TAG_BYTES
  function automatic logic [LEN_W-1:0] eff_len(input logic [4:0] tl);
    logic [LEN_W-1:0] n;
    if (tl == 5'd0) begin
      n = LEN_W'(1);
    end else if (int'(tl) > MAX_TAG_BYTES) begin
      n = LEN_W'(MAX_TAG_BYTES);
    end else begin
      n = LEN_W'(int'(tl));
    end
    return n;
  endfunction

endpackage

### rtl/rfr_cell.sv
`timescale 1ns / 1ps

module rfr_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rfr_pkg::cell_ctl_t ctl,
  input  logic              seed,       // 1 for the head cell
  input  logic              ptr_prev,   // pointer from the left neighbor
  input  logic [7:0]        data_next,  // byte from the right neighbor
  output logic              ptr,
  output logic [7:0]        data,
  output logic              mismatch
);

  logic       ptr_r, ptr_nxt;
  logic [7:0] data_r, data_nxt;

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctl.restart) begin
      ptr_nxt = seed;
    end else if (ctl.advance) begin
      ptr_nxt = ptr_prev;
    end
  end

  always_comb begin
    data_nxt = data_r;
    if (ctl.rotate) begin
      data_nxt = data_next;
    end else if (ctl.write && ptr_r) begin
      data_nxt = ctl.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign ptr = ptr_r;
  assign data = data_r;
  assign mismatch = ctl.compare && ptr_r && (data_r != ctl.rx_byte);

endmodule

### rtl/rfr_tag_chain.sv
`timescale 1ns / 1ps

// Ring of tag cells. A one-hot pointer walks left to right as bytes arrive;
// rotation moves every byte one cell toward the head.
module rfr_tag_chain (
  input  logic               clk,
  input  logic               rst_n,
  input  rfr_pkg::cell_ctl_t ctl,
  output logic [7:0]         head_byte,
  output logic               mismatch
);

  logic [rfr_pkg::MAX_TAG_BYTES-1:0] ptr;
  logic [rfr_pkg::MAX_TAG_BYTES-1:0] miss;
  logic [7:0]                        data [rfr_pkg::MAX_TAG_BYTES];

  for (genvar i = 0; i < rfr_pkg::MAX_TAG_BYTES; i++) begin : g_cell
    logic ptr_prev;
    if (i == 0) begin : g_head
      assign ptr_prev = 1'b0;
    end else begin : g_body
      assign ptr_prev = ptr[i-1];
    end

    rfr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .seed     ((i == 0) ? 1'b1 : 1'b0),
      .ptr_prev (ptr_prev),
      .data_next(data[(i + 1) % rfr_pkg::MAX_TAG_BYTES]),
      .ptr      (ptr[i]),
      .data     (data[i]),
      .mismatch (miss[i])
    );
  end

  assign head_byte = data[0];
  assign mismatch = |miss;

endmodule

### rtl/rfid_tag_frame_reader.sv
`timescale 1ns / 1ps

// Channel  | Ports                                   | Word
// ---------+-----------------------------------------+--------------------------
// input    | in_valid, in_ready, in_data             | in_item_t {cmd, rx_byte}
// result   | out_valid, out_ready, out_data          | out_item_t {status,...}
// config   | psel, penable, pwrite, paddr, pwdata,   | tag_length @0,
//          | prdata, pready                          | timeout_ticks @4
//
// Start, tick and byte words are taken whenever the input is not held off. A word that
// completes a good double read holds the input while the cell ring rotates once
// through all MAX_TAG_BYTES cells, showing the first tag_length bytes in turn;
// result stalls hold the rotation. Reset clears control only; tag cells are not cleared (no sweep).
// Input is held off while a result word waits and cannot be replaced.
module rfid_tag_frame_reader (
  input  logic                clk,
  input  logic                rst_n,
  // input words
  input  logic                in_valid,
  output logic                in_ready,
  input  rfr_pkg::in_item_t   in_data,
  // result words
  output logic                out_valid,
  input  logic                out_ready,
  output rfr_pkg::out_item_t  out_data,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;  // waiting for start byte
  localparam logic [1:0] PH_BODY = 2'd2;   // tag bytes, then stop byte

  localparam int IW = rfr_pkg::IDX_W;
  localparam int LW = rfr_pkg::LEN_W;

  // ---------------- registers ----------------
  logic [4:0]  tag_length_r;
  logic [31:0] timeout_r;

  logic          cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_length_r <= rfr_pkg::DEFAULT_TAG_LENGTH;
      timeout_r    <= 32'd0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rfr_pkg::REG_TAG_LENGTH: tag_length_r <= pwdata[4:0];
        rfr_pkg::REG_TIMEOUT:    timeout_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rfr_pkg::REG_TAG_LENGTH: prdata = {27'd0, tag_length_r};
      rfr_pkg::REG_TIMEOUT:    prdata = timeout_r;
      default:                 prdata = 32'd0;
    endcase
  end

  // ---------------- control state ----------------
  logic [1:0]    phase_r, phase_nxt;
  logic          second_r, second_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   elapsed_r, elapsed_nxt;
  logic          differ_r, differ_nxt;
  // emission: one full ring rotation
  logic          emit_r, emit_nxt;
  logic [IW-1:0] rot_r, rot_nxt;
  logic [LW-1:0] emit_len_r, emit_len_nxt;
  // result register
  logic               out_valid_r, out_valid_nxt;
  rfr_pkg::out_item_t out_data_r, out_data_nxt;

  logic          in_acc, out_free, step;
  logic [LW-1:0] n;
  logic [31:0]   elapsed_inc;
  logic          miss;
  logic [7:0]    head_byte;
  rfr_pkg::cell_ctl_t ctl;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !emit_r && out_free;
  assign in_acc = in_valid && in_ready;
  assign step = emit_r && out_free;
  assign n = rfr_pkg::eff_len(tag_length_r);
  assign elapsed_inc = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;

  rfr_tag_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .head_byte(head_byte),
    .mismatch (miss)
  );

  always_comb begin
    phase_nxt     = phase_r;
    second_nxt    = second_r;
    cnt_nxt       = cnt_r;
    elapsed_nxt   = elapsed_r;
    differ_nxt    = differ_r;
    emit_nxt      = emit_r;
    rot_nxt       = rot_r;
    emit_len_nxt  = emit_len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.rx_byte   = in_data.rx_byte;

    if (step) begin
      ctl.rotate = 1'b1;
      rot_nxt = rot_r + IW'(1);
      if ((LW+1)'(rot_r) < (LW+1)'(emit_len_r)) begin
        out_valid_nxt         = 1'b1;
        out_data_nxt.status   = rfr_pkg::ST_OK;
        out_data_nxt.tag_byte = head_byte;
        out_data_nxt.last     = (((LW+1)'(rot_r) + (LW+1)'(1)) == (LW+1)'(emit_len_r));
      end
      if (rot_r == IW'(rfr_pkg::MAX_TAG_BYTES - 1)) begin
        emit_nxt = 1'b0;
      end
    end

    if (in_acc) begin
      if (in_data.cmd == rfr_pkg::CMD_START) begin
        phase_nxt   = PH_START;
        second_nxt  = 1'b0;
        cnt_nxt     = '0;
        elapsed_nxt = 32'd0;
        differ_nxt  = 1'b0;
      end else if (phase_r != PH_IDLE) begin
        // failure word is built here and used only where a check fails
        out_data_nxt.tag_byte = 8'd0;
        out_data_nxt.last     = 1'b1;
        if (in_data.cmd == rfr_pkg::CMD_TICK) begin
          elapsed_nxt = elapsed_inc;
          if (timeout_r != 32'd0 && elapsed_inc > timeout_r) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = rfr_pkg::ST_TIMEOUT;
            phase_nxt           = PH_IDLE;
          end
        end else if (in_data.cmd == rfr_pkg::CMD_BYTE) begin
          if (phase_r == PH_START) begin
            if (in_data.rx_byte != rfr_pkg::START_BYTE) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = rfr_pkg::ST_BADSTART;
              phase_nxt           = PH_IDLE;
            end else begin
              phase_nxt   = PH_BODY;
              cnt_nxt     = '0;
              ctl.restart = 1'b1;
            end
          end else if (cnt_r >= n) begin
            // stop byte position
            if (in_data.rx_byte != rfr_pkg::STOP_BYTE || (second_r && differ_r)) begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = rfr_pkg::ST_FRAME;
              phase_nxt           = PH_IDLE;
            end else if (!second_r) begin
              second_nxt = 1'b1;
              phase_nxt  = PH_START;
              cnt_nxt    = '0;
            end else begin
              emit_nxt     = 1'b1;
              rot_nxt      = '0;
              emit_len_nxt = n;
              phase_nxt    = PH_IDLE;
            end
          end else begin
            // tag byte: pointed cell stores or checks it
            ctl.advance = 1'b1;
            ctl.write   = !second_r;
            ctl.compare = second_r;
            differ_nxt  = differ_r || miss;
            cnt_nxt     = cnt_r + LW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      second_r    <= 1'b0;
      cnt_r       <= '0;
      elapsed_r   <= 32'd0;
      differ_r    <= 1'b0;
      emit_r      <= 1'b0;
      rot_r       <= '0;
      emit_len_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      second_r    <= second_nxt;
      cnt_r       <= cnt_nxt;
      elapsed_r   <= elapsed_nxt;
      differ_r    <= differ_nxt;
      emit_r      <= emit_nxt;
      rot_r       <= rot_nxt;
      emit_len_r  <= emit_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != rfr_pkg::ST_OK
      |-> out_data_r.last && out_data_r.tag_byte == 8'd0)
    else $error("failure word not final or carries data");

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    emit_r |-> !in_ready)
    else $error("input taken during ring rotation");

  a_rotation_ends: assert property (@(posedge clk) disable iff (!rst_n)
    step && rot_r == IW'(rfr_pkg::MAX_TAG_BYTES - 1) |=> !emit_r)
    else $error("rotation did not end after one full turn");

  a_emit_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(emit_r) |-> phase_r == PH_IDLE && emit_len_r != '0)
    else $error("emission started with bad phase or length");

endmodule

### tb/rfr_frame_checker.sv
`timescale 1ns / 1ps

// Watches both word channels and the register port. Predicts the result words
// of each accepted input word and compares them in order.
module rfr_frame_checker
  import rfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef enum logic [1:0] {RD_IDLE, RD_SEEK_START, RD_IN_FRAME} read_phase_t;

  logic [4:0]  cfg_tag_length;
  logic [31:0] cfg_timeout;

  read_phase_t rd_phase;
  logic        on_second_copy;
  logic        copy_mismatch;
  logic [4:0]  body_count;
  logic [31:0] tick_count;
  logic [7:0]  first_copy [MAX_TAG_BYTES];

  out_item_t   expected_words [$];
  int unsigned mismatches = 0;

  // tag bytes per frame, register clamped to 1..MAX_TAG_BYTES
  function automatic logic [4:0] frame_length();
    if (cfg_tag_length == 5'd0) return 5'd1;
    if (int'(cfg_tag_length) > MAX_TAG_BYTES) return 5'(MAX_TAG_BYTES);
    return cfg_tag_length;
  endfunction

  task automatic end_read_with(input logic [1:0] code);
    expected_words.push_back('{status: code, tag_byte: 8'h00, last: 1'b1});
    rd_phase = RD_IDLE;
  endtask

  task automatic predict_word(input in_item_t w);
    logic [4:0] n;
    n = frame_length();
    if (w.cmd == CMD_START) begin
      rd_phase = RD_SEEK_START;
      on_second_copy = 1'b0;
      body_count = '0;
      tick_count = '0;
      copy_mismatch = 1'b0;
    end else if (rd_phase != RD_IDLE) begin
      case (w.cmd)
        CMD_TICK: begin
          if (tick_count != 32'hFFFF_FFFF) tick_count++;
          if (cfg_timeout != 0 && tick_count > cfg_timeout) end_read_with(ST_TIMEOUT);
        end
        CMD_BYTE: begin
          if (rd_phase == RD_SEEK_START) begin
            if (w.rx_byte != START_BYTE) begin
              end_read_with(ST_BADSTART);
            end else begin
              rd_phase = RD_IN_FRAME;
              body_count = '0;
            end
          end else if (body_count >= n) begin
            if (w.rx_byte != STOP_BYTE) begin
              end_read_with(ST_FRAME);
            end else if (!on_second_copy) begin
              on_second_copy = 1'b1;
              rd_phase = RD_SEEK_START;
              body_count = '0;
            end else if (copy_mismatch) begin
              end_read_with(ST_FRAME);
            end else begin
              for (int i = 0; i < n; i++)
                expected_words.push_back('{status: ST_OK, tag_byte: first_copy[i],
                                           last: (i + 1 == int'(n))});
              rd_phase = RD_IDLE;
            end
          end else begin
            // n never exceeds the store depth, so body_count indexes it safely
            if (!on_second_copy) first_copy[body_count] = w.rx_byte;
            else if (first_copy[body_count] != w.rx_byte) copy_mismatch = 1'b1;
            body_count++;
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cfg_tag_length = DEFAULT_TAG_LENGTH;
      cfg_timeout = '0;
      rd_phase = RD_IDLE;
      on_second_copy = 1'b0;
      copy_mismatch = 1'b0;
      body_count = '0;
      tick_count = '0;
      foreach (first_copy[i]) first_copy[i] = 8'h00;
      expected_words.delete();
    end else begin
      // results leaving now belong to words taken earlier
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: status %0d tag_byte %02h last %0d",
                 out_data.status, out_data.tag_byte, out_data.last);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.tag_byte !== want.tag_byte) begin
            $error("tag_byte: expected %02h, actual %02h", want.tag_byte, out_data.tag_byte);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data.last);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) predict_word(in_data);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TAG_LENGTH) cfg_tag_length = pwdata[4:0];
        else cfg_timeout = pwdata;
      end
    end
    fail_count <= mismatches;
    pending <= expected_words.size();
  end

endmodule

### tb/rfid_tag_frame_reader_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the tag frame reader. Checking lives in
// rfr_frame_checker; this module only drives words, register writes and result ready.
module rfid_tag_frame_reader_test;
  import rfr_pkg::*;

  // cmd value the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // register byte addresses, index in bit 2
  localparam logic [2:0] ADDR_TAG_LENGTH = {REG_TAG_LENGTH, 2'b00};
  localparam logic [2:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};

  localparam int RANDOM_WORDS = 230;
  localparam int WORDS_PER_SETTING = 30;
  // a good read holds input for one full ring rotation; leave room for that
  localparam int SETTLE_CYCLES = 40;
  // cycles with no word, result or register access before giving up
  localparam int STALL_LIMIT = 4000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;

  // stimulus knobs, changed per register setting
  int          frame_len = 10;
  int          tick_pct = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;
  int unsigned sent_words = 0;
  logic [7:0]  tag_copy [MAX_TAG_BYTES];

  rfid_tag_frame_reader i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rfr_frame_checker i_frame_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // result side back-pressure; a calm setting keeps ready high throughout
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm_out && $urandom_range(0, 99) < 30) stall_left <= pause_len();
    end
  end

  // watchdog: any accepted word, result or register access counts as progress
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one input word; optional idle gap first, valid held until taken
  task automatic send_word(input logic [1:0] word_cmd, input logic [7:0] word_byte);
    int gap;
    gap = (!calm_in && $urandom_range(0, 99) < 35) ? pause_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: word_cmd, rx_byte: word_byte};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_words++;
  endtask

  // serial byte, sometimes preceded by a tick or an ignored code
  task automatic send_byte(input logic [7:0] rx);
    if ($urandom_range(0, 99) < tick_pct) send_word(CMD_TICK, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 2) send_word(CMD_UNUSED, 8'($urandom_range(0, 255)));
    send_word(CMD_BYTE, rx);
  endtask

  // one frame of the current tag; flip_mask corrupts the byte at flip_at
  task automatic send_frame(input logic [7:0] open_byte, input logic [7:0] close_byte,
                            input int flip_at, input logic [7:0] flip_mask);
    send_byte(open_byte);
    for (int i = 0; i < frame_len; i++)
      send_byte(tag_copy[i] ^ ((i == flip_at) ? flip_mask : 8'h00));
    send_byte(close_byte);
  endtask

  // stop sending and let every predicted result drain
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then psel low again
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with nothing in flight; every read after this
  // begins with a start word, so the store is always filled before compared
  task automatic new_setting(input logic [4:0] len, input logic [31:0] limit);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    // upper bits of the length word carry junk the register must drop
    write_reg(ADDR_TAG_LENGTH, {27'($urandom()), len});
    write_reg(ADDR_TIMEOUT, limit);
    frame_len = (len == 5'd0) ? 1 : ((int'(len) > MAX_TAG_BYTES) ? MAX_TAG_BYTES : int'(len));
    tick_pct = (limit == 0) ? 5 : $urandom_range(2, 12);
    calm_in = ($urandom_range(0, 3) == 0);
    calm_out <= ($urandom_range(0, 3) == 0);
  endtask

  // one read attempt: mostly clean double reads, then broken variants and noise
  task automatic run_read();
    int kind;
    for (int i = 0; i < frame_len; i++) tag_copy[i] = 8'($urandom_range(0, 255));
    kind = $urandom_range(0, 99);
    send_word(CMD_START, 8'($urandom_range(0, 255)));
    if (kind < 55) begin
      send_frame(START_BYTE, STOP_BYTE, -1, 8'h00);
      send_frame(START_BYTE, STOP_BYTE, -1, 8'h00);
    end else if (kind < 65) begin
      // second copy differs in one byte
      send_frame(START_BYTE, STOP_BYTE, -1, 8'h00);
      send_frame(START_BYTE, STOP_BYTE, $urandom_range(0, frame_len - 1),
                 8'($urandom_range(1, 255)));
    end else if (kind < 72) begin
      // stop byte missing in the first or the second copy
      if ($urandom_range(0, 1) == 0) begin
        send_frame(START_BYTE, STOP_BYTE ^ 8'($urandom_range(1, 255)), -1, 8'h00);
      end else begin
        send_frame(START_BYTE, STOP_BYTE, -1, 8'h00);
        send_frame(START_BYTE, STOP_BYTE ^ 8'($urandom_range(1, 255)), -1, 8'h00);
      end
    end else if (kind < 79) begin
      // wrong start byte on either copy
      if ($urandom_range(0, 1) == 1) send_frame(START_BYTE, STOP_BYTE, -1, 8'h00);
      send_byte(START_BYTE ^ 8'($urandom_range(1, 255)));
    end else if (kind < 86) begin
      // partial frame; the next read's start word drops it
      send_byte(START_BYTE);
      repeat ($urandom_range(0, frame_len)) send_byte(8'($urandom_range(0, 255)));
    end else if (kind < 93) begin
      repeat ($urandom_range(4, 10))
        send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end else begin
      // tick run, long enough to trip small limits
      repeat ($urandom_range(1, 60)) send_word(CMD_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned random_from;
    int unsigned setting_from;
    int          setting_idx;
    logic [4:0]  len;
    logic [31:0] limit;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: two tag bytes, timeout limit of three ticks
    new_setting(5'd2, 32'd3);
    tick_pct = 0;
    // idle block ignores bytes, ticks and the unused code
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_TICK, 8'h00);
    send_word(CMD_UNUSED, 8'hFF);
    // clean double read with extreme tag bytes
    send_word(CMD_START, 8'h00);
    repeat (2) begin
      send_word(CMD_BYTE, START_BYTE);
      send_word(CMD_BYTE, 8'h00);
      send_word(CMD_BYTE, 8'hFF);
      send_word(CMD_BYTE, STOP_BYTE);
    end
    // unused code mid-read is ignored, a start mid-read restarts, then bad start
    send_word(CMD_START, 8'hFF);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_BYTE, 8'h11);
    send_word(CMD_UNUSED, 8'h00);
    send_word(CMD_START, 8'h00);
    send_word(CMD_BYTE, 8'h55);
    // stop byte missing after the tag bytes
    send_word(CMD_START, 8'h00);
    send_word(CMD_BYTE, START_BYTE);
    send_word(CMD_BYTE, 8'h11);
    send_word(CMD_BYTE, 8'h22);
    send_word(CMD_BYTE, 8'h33);
    // fourth tick exceeds the limit of three
    send_word(CMD_START, 8'h00);
    repeat (4) send_word(CMD_TICK, 8'h00);

    // random part: cycle through register settings, extremes included
    random_from = sent_words;
    setting_idx = 0;
    while (sent_words - random_from < RANDOM_WORDS) begin
      case (setting_idx % 8)
        0: begin len = 5'd1;  limit = 32'd0; end
        1: begin len = 5'd16; limit = 32'hFFFF_FFFF; end
        2: begin len = 5'd0;  limit = 32'($urandom_range(5, 40)); end
        3: begin len = 5'd31; limit = 32'd0; end
        4: begin len = 5'd17; limit = $urandom(); end
        5: begin len = 5'($urandom_range(2, 6)); limit = 32'($urandom_range(1, 20)); end
        6: begin len = 5'($urandom_range(0, 31)); limit = 32'd0; end
        default: begin len = 5'($urandom_range(1, 4)); limit = 32'hFFFF_FFFF; end
      endcase
      new_setting(len, limit);
      setting_from = sent_words;
      while (sent_words - setting_from < WORDS_PER_SETTING &&
             sent_words - random_from < RANDOM_WORDS) begin
        run_read();
        // occasionally hold off until the block has emptied
        if ($urandom_range(0, 15) == 0) wait_drained();
      end
      setting_idx++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
